/* rtl/esct_pkg.sv */
// ----------------------------------------------------------------------------
// esct_pkg
// Shared types and constants of the edge sign count table.
// ----------------------------------------------------------------------------
package esct_pkg;

	localparam int OP_W    = 2;
	localparam int ID_W    = 10;
	localparam int SC_W    = 11;
	localparam int RD_W    = 32;
	localparam int TALLY_W = 32;

	localparam logic [SC_W-1:0] SC_RESET = 11'd1024;

	typedef enum logic [OP_W-1:0] {
		OP_SET_PRESENCE = 2'd0,
		OP_APPLY_EDGE   = 2'd1,
		OP_READ_ENTRY   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RD_A,
		S_RD_B,
		S_WR_A,
		S_WR_B,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd_a;
		logic rd_b;
		logic wr_a;
		logic wr_b;
		logic resp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_mem;
		logic op_edge;
		logic op_set;
		logic slot_free;
		logic clear_last;
	} dp_status_t;

endpackage

/* rtl/esct_if.sv */
// ----------------------------------------------------------------------------
// esct_req_if / esct_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface esct_req_if;
	import esct_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ID_W-1:0]    first_id;
	logic [ID_W-1:0]    second_id;
	logic               is_positive;
	logic               presence_value;

	modport source (
		output valid, operation, first_id, second_id, is_positive, presence_value,
		input  ready
	);
	modport sink (
		input  valid, operation, first_id, second_id, is_positive, presence_value,
		output ready
	);
endinterface

interface esct_rsp_if;
	import esct_pkg::*;

	logic               valid;
	logic               ready;
	logic               edge_mapped;
	logic               mapping_error;
	logic [RD_W-1:0]    read_total;
	logic [RD_W-1:0]    read_positive;
	logic [RD_W-1:0]    read_negative;
	logic               read_presence;
	logic [TALLY_W-1:0] mapped_edge_total;

	modport source (
		output valid, edge_mapped, mapping_error, read_total, read_positive,
		       read_negative, read_presence, mapped_edge_total,
		input  ready
	);
	modport sink (
		input  valid, edge_mapped, mapping_error, read_total, read_positive,
		       read_negative, read_presence, mapped_edge_total,
		output ready
	);
endinterface

/* rtl/edge_sign_count_table.sv */
// ----------------------------------------------------------------------------
// edge_sign_count_table
// Per-symbol presence bit and saturating total/positive/negative counters.
// ----------------------------------------------------------------------------
// All table state sits in one single-port memory word per symbol. Each item
// passes an accept state, a state per table access and a response state: a
// presence load reads and writes one entry, a mapped edge reads and writes
// both, a read only reads, and an unmapped edge or an unused operation code
// skips the table. After reset a clearing pass zeroes the table while request
// ready stays low. A result waits in the output register until taken; the next
// request is accepted meanwhile. symbol_count may be written only while idle.
module edge_sign_count_table #(
	parameter int MAX_SYMBOLS = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [esct_pkg::SC_W-1:0] cfg_wdata,
	esct_req_if.sink                  request,
	esct_rsp_if.source                response
);
	import esct_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       in_ready;

	assign request.ready = in_ready;

	esct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	esct_dp #(
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.operation         (request.operation),
		.first_id          (request.first_id),
		.second_id         (request.second_id),
		.is_positive       (request.is_positive),
		.presence_value    (request.presence_value),
		.cmd               (cmd),
		.status            (status),
		.out_ready         (response.ready),
		.out_valid         (response.valid),
		.edge_mapped       (response.edge_mapped),
		.mapping_error     (response.mapping_error),
		.read_total        (response.read_total),
		.read_positive     (response.read_positive),
		.read_negative     (response.read_negative),
		.read_presence     (response.read_presence),
		.mapped_edge_total (response.mapped_edge_total)
	);

endmodule

/* rtl/esct_ctrl.sv */
// ----------------------------------------------------------------------------
// esct_ctrl
// Sequencer: clearing pass, then per item the memory accesses and response.
// ----------------------------------------------------------------------------
module esct_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  esct_pkg::dp_status_t  status,
	output esct_pkg::ctrl_cmd_t   cmd
);
	import esct_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.need_mem ? S_RD_A : S_RESP;
				end
			end
			S_RD_A: begin
				cmd.rd_a = 1'b1;
				if (status.op_edge) begin
					state_d = S_RD_B;
				end else if (status.op_set) begin
					state_d = S_WR_A;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_a = 1'b1;
				state_d  = status.op_edge ? S_WR_B : S_RESP;
			end
			S_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				if (status.slot_free) begin
					cmd.resp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/esct_dp.sv */
// ----------------------------------------------------------------------------
// esct_dp
// Table memory, item registers, counter update, edge tally and result register.
// ----------------------------------------------------------------------------
module esct_dp #(
	parameter int MAX_SYMBOLS = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [esct_pkg::SC_W-1:0]     cfg_wdata,
	input  logic [esct_pkg::OP_W-1:0]     operation,
	input  logic [esct_pkg::ID_W-1:0]     first_id,
	input  logic [esct_pkg::ID_W-1:0]     second_id,
	input  logic                          is_positive,
	input  logic                          presence_value,
	input  esct_pkg::ctrl_cmd_t           cmd,
	output esct_pkg::dp_status_t          status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          edge_mapped,
	output logic                          mapping_error,
	output logic [esct_pkg::RD_W-1:0]     read_total,
	output logic [esct_pkg::RD_W-1:0]     read_positive,
	output logic [esct_pkg::RD_W-1:0]     read_negative,
	output logic                          read_presence,
	output logic [esct_pkg::TALLY_W-1:0]  mapped_edge_total
);
	import esct_pkg::*;

	localparam int AW     = $clog2(MAX_SYMBOLS);
	localparam int CW     = COUNT_WIDTH;
	localparam int WORD_W = 1 + 3 * CW;
	localparam int PB     = 3 * CW;
	localparam int EXT_W  = (AW > ID_W) ? AW : ID_W;
	localparam int CE_W   = (CW > RD_W) ? CW : RD_W;

	// word layout: presence, total, positive, negative
	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + CW'(1);
	endfunction

	function automatic logic [WORD_W-1:0] bump(input logic [WORD_W-1:0] w, input logic p);
		logic [CW-1:0] t;
		logic [CW-1:0] ps;
		logic [CW-1:0] ng;
		t  = w[3*CW-1:2*CW];
		ps = w[2*CW-1:CW];
		ng = w[CW-1:0];
		t  = sat_inc(t);
		if (p) begin
			ps = sat_inc(ps);
		end else begin
			ng = sat_inc(ng);
		end
		return {w[PB], t, ps, ng};
	endfunction

	logic [WORD_W-1:0]  mem [MAX_SYMBOLS];
	logic [WORD_W-1:0]  rdata_q;
	logic [WORD_W-1:0]  word_a_q;
	logic [WORD_W-1:0]  word_b_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [SC_W-1:0]    sc_q;
	logic [TALLY_W-1:0] tally_q;

	logic [OP_W-1:0]    op_q;
	logic [ID_W-1:0]    a_q;
	logic [ID_W-1:0]    b_q;
	logic               pos_q;
	logic               pval_q;
	logic               em_q;
	logic               me_q;
	logic               rd_ok_q;

	logic               a_lt_max;
	logic               b_lt_max;
	logic               both_mapped;
	logic               edge_ok;
	logic               need_mem;
	logic [EXT_W-1:0]   a_ext;
	logic [EXT_W-1:0]   b_ext;
	logic [AW-1:0]      addr_a;
	logic [AW-1:0]      addr_b;
	logic [AW-1:0]      mem_addr;
	logic               mem_we;
	logic               mem_re;
	logic [WORD_W-1:0]  mem_wdata;
	logic [WORD_W-1:0]  bumped_a;
	logic [WORD_W-1:0]  bumped_b;
	logic [CE_W-1:0]    t_ext;
	logic [CE_W-1:0]    p_ext;
	logic [CE_W-1:0]    n_ext;

	// incoming item classification
	assign a_lt_max    = 32'(first_id) < 32'(MAX_SYMBOLS);
	assign b_lt_max    = 32'(second_id) < 32'(MAX_SYMBOLS);
	assign both_mapped = a_lt_max && b_lt_max
		&& ({1'b0, first_id} < sc_q) && ({1'b0, second_id} < sc_q);
	assign edge_ok     = (operation == OP_APPLY_EDGE) && both_mapped;

	always_comb begin
		case (operation)
			OP_SET_PRESENCE: need_mem = a_lt_max;
			OP_APPLY_EDGE:   need_mem = both_mapped;
			OP_READ_ENTRY:   need_mem = a_lt_max;
			default:         need_mem = 1'b0;
		endcase
	end

	assign status.need_mem   = need_mem;
	assign status.op_edge    = (op_q == OP_APPLY_EDGE);
	assign status.op_set     = (op_q == OP_SET_PRESENCE);
	assign status.slot_free  = !out_valid || out_ready;
	assign status.clear_last = (clr_cnt_q == AW'(MAX_SYMBOLS - 1));

	// memory port
	assign a_ext    = EXT_W'(a_q);
	assign b_ext    = EXT_W'(b_q);
	assign addr_a   = a_ext[AW-1:0];
	assign addr_b   = b_ext[AW-1:0];
	assign bumped_a = bump(word_a_q, pos_q);
	assign bumped_b = bump(word_b_q, pos_q);

	always_comb begin
		mem_addr  = addr_a;
		mem_we    = 1'b0;
		mem_wdata = bumped_a;
		if (cmd.clr) begin
			mem_addr  = clr_cnt_q;
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (cmd.rd_b) begin
			mem_addr = addr_b;
		end else if (cmd.wr_a) begin
			if (op_q == OP_SET_PRESENCE) begin
				mem_we    = 1'b1;
				mem_wdata = {pval_q, rdata_q[PB-1:0]};
			end else begin
				// entry a is bumped when b is present
				mem_we    = rdata_q[PB];
				mem_wdata = bumped_a;
			end
		end else if (cmd.wr_b) begin
			mem_addr  = addr_b;
			mem_we    = word_a_q[PB];
			mem_wdata = bumped_b;
		end
	end

	assign mem_re = cmd.rd_a || cmd.rd_b;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// item registers and edge operands
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= operation;
			a_q     <= first_id;
			b_q     <= second_id;
			pos_q   <= is_positive;
			pval_q  <= presence_value;
			em_q    <= edge_ok;
			me_q    <= (operation == OP_APPLY_EDGE) && !both_mapped;
			rd_ok_q <= (operation == OP_READ_ENTRY) && a_lt_max;
		end
		if (cmd.rd_b) begin
			word_a_q <= rdata_q;
		end
		if (cmd.wr_a) begin
			// self-edge: second bump starts from the first one
			if ((a_q == b_q) && rdata_q[PB]) begin
				word_b_q <= bumped_a;
			end else begin
				word_b_q <= rdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			sc_q      <= SC_RESET;
			tally_q   <= '0;
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cfg_we) begin
				sc_q <= cfg_wdata;
			end
			if (cmd.load && edge_ok && !(&tally_q)) begin
				tally_q <= tally_q + TALLY_W'(1);
			end
		end
	end

	// result register
	assign t_ext = CE_W'(rdata_q[3*CW-1:2*CW]);
	assign p_ext = CE_W'(rdata_q[2*CW-1:CW]);
	assign n_ext = CE_W'(rdata_q[CW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.resp) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.resp) begin
			edge_mapped       <= em_q;
			mapping_error     <= me_q;
			read_total        <= rd_ok_q ? t_ext[RD_W-1:0] : '0;
			read_positive     <= rd_ok_q ? p_ext[RD_W-1:0] : '0;
			read_negative     <= rd_ok_q ? n_ext[RD_W-1:0] : '0;
			read_presence     <= rd_ok_q && rdata_q[PB];
			mapped_edge_total <= tally_q;
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks edge_sign_count_table against a shadow copy of its symbol table.
// A short scripted run covers the reset state, the id extremes, self edges,
// edges with zero, one or two present endpoints, unmapped ids and the unused
// operation code. Random items then run under several symbol counts, with
// random sender and receiver idling, one long receiver hold-off and full
// drains. Every result is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
	import esct_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int MAX_ID         = (1 << ID_W) - 1;
	localparam int STALL_LIMIT    = 4000;
	localparam int HOLD_OFF       = 300;
	localparam int TAIL_CYCLES    = 16;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_b;
		logic            positive;
		logic            presence;
	} item_t;

	typedef struct packed {
		logic               mapped;
		logic               map_err;
		logic [RD_W-1:0]    total;
		logic [RD_W-1:0]    pos_cnt;
		logic [RD_W-1:0]    neg_cnt;
		logic               presence;
		logic [TALLY_W-1:0] tally;
	} result_t;

	typedef struct packed {
		logic            is_cfg;
		logic [SC_W-1:0] cfg_val;
		item_t           it;
		logic            typed;
		result_t         want;
	} row_t;

	typedef struct {
		int sym_count;
		int tx_pct;
		int rx_pct;
		int items;
	} phase_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [SC_W-1:0] cfg_wdata;

	esct_req_if req_ch ();
	esct_rsp_if rsp_ch ();

	edge_sign_count_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (req_ch),
		.response  (rsp_ch)
	);

	// shadow of the block's table
	logic               shadow_presence [1024];
	logic [RD_W-1:0]    shadow_total    [1024];
	logic [RD_W-1:0]    shadow_pos      [1024];
	logic [RD_W-1:0]    shadow_neg      [1024];
	logic [TALLY_W-1:0] shadow_tally;
	logic [SC_W-1:0]    shadow_sc;

	result_t results_due [$];
	row_t    script [$];
	phase_t  plan [4] = '{
		'{1024, 7, 68, 560},
		'{37, 68, 7, 540},
		'{1, 0, 0, 100},
		'{700, 0, 0, 500}
	};

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold;
	int fault_count;
	int stall_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [RD_W-1:0] sat_inc(logic [RD_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic void bump_counts(logic [ID_W-1:0] id, logic positive);
		shadow_total[id] = sat_inc(shadow_total[id]);
		if (positive) begin
			shadow_pos[id] = sat_inc(shadow_pos[id]);
		end else begin
			shadow_neg[id] = sat_inc(shadow_neg[id]);
		end
	endfunction

	function automatic result_t update_shadow_table(item_t it);
		result_t r;
		logic    pa;
		logic    pb;
		r = '0;
		case (it.op)
			OP_SET_PRESENCE: begin
				shadow_presence[it.id_a] = it.presence;
			end
			OP_APPLY_EDGE: begin
				if ({1'b0, it.id_a} < shadow_sc && {1'b0, it.id_b} < shadow_sc) begin
					pa = shadow_presence[it.id_a];
					pb = shadow_presence[it.id_b];
					if (pa != pb) begin
						bump_counts(pa ? it.id_b : it.id_a, it.positive);
					end else if (pa) begin
						bump_counts(it.id_a, it.positive);
						bump_counts(it.id_b, it.positive);
					end
					if (shadow_tally != '1) begin
						shadow_tally = shadow_tally + 1'b1;
					end
					r.mapped = 1'b1;
				end else begin
					r.map_err = 1'b1;
				end
			end
			OP_READ_ENTRY: begin
				r.total    = shadow_total[it.id_a];
				r.pos_cnt  = shadow_pos[it.id_a];
				r.neg_cnt  = shadow_neg[it.id_a];
				r.presence = shadow_presence[it.id_a];
			end
			default: begin
			end
		endcase
		r.tally = shadow_tally;
		return r;
	endfunction

	function automatic item_t make_item(logic [OP_W-1:0] op, int a, int b, bit pos, bit pval);
		item_t it;
		it.op       = op;
		it.id_a     = a[ID_W-1:0];
		it.id_b     = b[ID_W-1:0];
		it.positive = pos;
		it.presence = pval;
		return it;
	endfunction

	function automatic result_t res(bit m, bit e, int tot, int p, int n, bit pr, int t);
		result_t r;
		r.mapped   = m;
		r.map_err  = e;
		r.total    = tot;
		r.pos_cnt  = p;
		r.neg_cnt  = n;
		r.presence = pr;
		r.tally    = t;
		return r;
	endfunction

	function automatic void add_cfg(int v);
		row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_val = v[SC_W-1:0];
		script.push_back(r);
	endfunction

	function automatic void add_op(logic [OP_W-1:0] op, int a, int b, bit pos, bit pval);
		row_t r;
		r    = '0;
		r.it = make_item(op, a, b, pos, pval);
		script.push_back(r);
	endfunction

	function automatic void add_checked(logic [OP_W-1:0] op, int a, int b, bit pos, bit pval,
			result_t want);
		row_t r;
		r       = '0;
		r.it    = make_item(op, a, b, pos, pval);
		r.typed = 1'b1;
		r.want  = want;
		script.push_back(r);
	endfunction

	function automatic logic [ID_W-1:0] pick_id(int sc);
		int r;
		int span;
		int v;
		r    = $urandom_range(9);
		span = (sc > 16) ? 16 : sc;
		if (r < 3 && span > 0) begin
			v = $urandom_range(span - 1);
		end else if (r < 6 && span > 0) begin
			v = sc - 1 - int'($urandom_range(span - 1));
		end else if (r < 8) begin
			v = $urandom_range(MAX_ID);
		end else begin
			v = sc + int'($urandom_range(3));
		end
		if (v > MAX_ID) begin
			v = MAX_ID;
		end
		return v[ID_W-1:0];
	endfunction

	function automatic item_t random_item(int sc);
		item_t it;
		int    r;
		r = $urandom_range(99);
		if (r < 14) begin
			it.op = OP_SET_PRESENCE;
		end else if (r < 68) begin
			it.op = OP_APPLY_EDGE;
		end else if (r < 95) begin
			it.op = OP_READ_ENTRY;
		end else begin
			it.op = OP_UNUSED;
		end
		it.id_a     = pick_id(sc);
		it.id_b     = pick_id(sc);
		it.positive = 1'($urandom_range(1));
		it.presence = 1'($urandom_range(1));
		return it;
	endfunction

	task automatic issue_item(item_t it, logic typed, result_t want);
		result_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.operation      <= it.op;
		req_ch.first_id       <= it.id_a;
		req_ch.second_id      <= it.id_b;
		req_ch.is_positive    <= it.positive;
		req_ch.presence_value <= it.presence;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = update_shadow_table(it);
		results_due.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		@(posedge clk);
	endtask

	task automatic write_symbol_count(logic [SC_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		shadow_sc = v;
	endtask

	// receiver
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				rx_hold--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.mapped   = rsp_ch.edge_mapped;
			got.map_err  = rsp_ch.mapping_error;
			got.total    = rsp_ch.read_total;
			got.pos_cnt  = rsp_ch.read_positive;
			got.neg_cnt  = rsp_ch.read_negative;
			got.presence = rsp_ch.read_presence;
			got.tally    = rsp_ch.mapped_edge_total;
			if (results_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected result, tally=%0d", $realtime, got.tally);
				end
			end else begin
				want = results_due.pop_front();
				if (got.mapped !== want.mapped || got.map_err !== want.map_err ||
						got.total !== want.total || got.pos_cnt !== want.pos_cnt ||
						got.neg_cnt !== want.neg_cnt || got.presence !== want.presence ||
						got.tally !== want.tally) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("%0t: mismatch exp map=%0d err=%0d tot=%0d pos=%0d neg=%0d pres=%0d tally=%0d",
							$realtime, want.mapped, want.map_err, want.total, want.pos_cnt,
							want.neg_cnt, want.presence, want.tally);
						$display("%0t:          got map=%0d err=%0d tot=%0d pos=%0d neg=%0d pres=%0d tally=%0d",
							$realtime, got.mapped, got.map_err, got.total, got.pos_cnt,
							got.neg_cnt, got.presence, got.tally);
					end
				end
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stall_count = 0;
		end else begin
			stall_count++;
		end
		if (stall_count >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		fault_count = 0;
		stall_count = 0;
		rx_hold     = 0;
		tx_idle_pct = 7;
		rx_idle_pct = 68;
		shadow_tally = '0;
		shadow_sc    = SC_RESET;
		for (int i = 0; i < 1024; i++) begin
			shadow_presence[i] = 1'b0;
			shadow_total[i]    = '0;
			shadow_pos[i]      = '0;
			shadow_neg[i]      = '0;
		end
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.operation      <= OP_SET_PRESENCE;
		req_ch.first_id       <= '0;
		req_ch.second_id      <= '0;
		req_ch.is_positive    <= 1'b0;
		req_ch.presence_value <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_checked(OP_READ_ENTRY, 0, 0, 0, 0, res(0, 0, 0, 0, 0, 0, 0));
		add_checked(OP_READ_ENTRY, MAX_ID, MAX_ID, 1, 1, res(0, 0, 0, 0, 0, 0, 0));
		add_op(OP_SET_PRESENCE, 5, 0, 0, 1);
		add_checked(OP_APPLY_EDGE, 5, MAX_ID, 1, 0, res(1, 0, 0, 0, 0, 0, 1));
		add_checked(OP_APPLY_EDGE, MAX_ID, 5, 0, 0, res(1, 0, 0, 0, 0, 0, 2));
		add_checked(OP_READ_ENTRY, MAX_ID, 0, 0, 0, res(0, 0, 2, 1, 1, 0, 2));
		add_op(OP_SET_PRESENCE, MAX_ID, 0, 1, 1);
		add_op(OP_APPLY_EDGE, 5, MAX_ID, 1, 0);
		add_op(OP_APPLY_EDGE, 5, 5, 0, 0);
		add_op(OP_APPLY_EDGE, 0, 1, 1, 1);
		add_op(OP_READ_ENTRY, 5, 0, 0, 0);
		add_op(OP_READ_ENTRY, MAX_ID, 0, 0, 0);
		add_op(OP_SET_PRESENCE, 5, 0, 0, 0);
		add_op(OP_APPLY_EDGE, 5, 5, 1, 0);
		add_checked(OP_UNUSED, MAX_ID, MAX_ID, 1, 1, res(0, 0, 0, 0, 0, 0, 6));
		add_cfg(0);
		add_checked(OP_APPLY_EDGE, 0, 0, 1, 0, res(0, 1, 0, 0, 0, 0, 6));
		add_op(OP_SET_PRESENCE, 0, 0, 0, 1);
		add_op(OP_READ_ENTRY, 0, 0, 0, 0);
		add_cfg(1);
		add_op(OP_APPLY_EDGE, 0, 0, 1, 0);
		add_checked(OP_APPLY_EDGE, 0, 1, 0, 0, res(0, 1, 0, 0, 0, 0, 7));
		add_checked(OP_APPLY_EDGE, 1, 0, 1, 1, res(0, 1, 0, 0, 0, 0, 7));
		add_op(OP_READ_ENTRY, 0, 0, 0, 0);
		add_cfg(1024);
		add_op(OP_APPLY_EDGE, MAX_ID, 0, 0, 1);
		add_op(OP_READ_ENTRY, MAX_ID, 0, 0, 0);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				write_symbol_count(script[i].cfg_val);
			end else begin
				issue_item(script[i].it, script[i].typed, script[i].want);
			end
		end

		for (int p = 0; p < 4; p++) begin
			write_symbol_count(plan[p].sym_count[SC_W-1:0]);
			tx_idle_pct = plan[p].tx_pct;
			rx_idle_pct = plan[p].rx_pct;
			if (p == 3) begin
				rx_hold = HOLD_OFF;
			end
			for (int k = 0; k < plan[p].items; k++) begin
				if (p == 0 && k == plan[p].items / 2) begin
					drain_results();
				end
				issue_item(random_item(plan[p].sym_count), 1'b0, '0);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

/* edge_sign_count_table.f */
rtl/esct_pkg.sv
rtl/esct_if.sv
rtl/esct_ctrl.sv
rtl/esct_dp.sv
rtl/edge_sign_count_table.sv
sim/testbench.sv
